// ----- hw/rtl/trial_division_prime_test_defines.svh -----
// Assertion macros shared by the trial division prime test RTL.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and masked during reset.
`define TDPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and masked during reset.
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tdpt_pkg.sv -----
// Package with the constants and the small prime table of the prime tester.
package tdpt_pkg;

  localparam int unsigned TdptWidth     = 32;
  localparam int unsigned NumSmallPrime = 12;
  localparam int unsigned IdxW          = 4;
  localparam int unsigned PrimeW        = 6;
  localparam logic [PrimeW-1:0] FirstOddDivisor = 6'd41;
  localparam logic [IdxW-1:0]   LastSmallIdx    = 4'(NumSmallPrime - 1);

  function automatic logic [PrimeW-1:0] small_prime(input logic [IdxW-1:0] idx);
    logic [PrimeW-1:0] p;
    case (idx)
      4'd0:    p = 6'd2;
      4'd1:    p = 6'd3;
      4'd2:    p = 6'd5;
      4'd3:    p = 6'd7;
      4'd4:    p = 6'd11;
      4'd5:    p = 6'd13;
      4'd6:    p = 6'd17;
      4'd7:    p = 6'd19;
      4'd8:    p = 6'd23;
      4'd9:    p = 6'd29;
      4'd10:   p = 6'd31;
      4'd11:   p = 6'd37;
      default: p = 6'd37;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/tdpt_divider.sv -----
// Restoring divider that yields one quotient bit per cycle.
module tdpt_divider #(
  parameter int unsigned WIDTH = tdpt_pkg::TdptWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o,
  output logic             done_o
);
  import tdpt_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH);

  logic             running_q, running_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dvd_q, dvd_d;
  logic [WIDTH-1:0] div_q, div_d;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign shifted = {rem_q, dvd_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    running_d = running_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    div_d     = div_q;
    if (start_i) begin
      running_d = 1'b1;
      cnt_d     = CntW'(WIDTH - 1);
      rem_d     = '0;
      dvd_d     = dividend_i;
      div_d     = divisor_i;
    end else if (running_q) begin
      if (!diff[WIDTH]) begin
        rem_d = diff[WIDTH-1:0];
      end else begin
        rem_d = shifted[WIDTH-1:0];
      end
      dvd_d = {dvd_q[WIDTH-2:0], ~diff[WIDTH]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

// ----- hw/rtl/trial_division_prime_test.sv -----
// Top level of the trial division prime tester: sequencer around a shared divider.
// Usage:
// A number is taken on candidate_i at a rising edge where start is high and
// busy is low. For numbers from 2 up, busy then stays high until the test has finished.
// The answer appears on prime_flag_o for exactly one cycle, marked by done_o;
// the receiver must take that beat, as it cannot hold results off.
// Numbers below 2 are answered in the cycle after the start beat.
// Otherwise each trial divisor goes through a launch state and then WIDTH steps
// of the shared bit-serial divider, which gives quotient and remainder together;
// the quotient supplies the divisor-squared bound.
// The twelve small primes 2 to 37 come first, then odd divisors from 41 while
// the divisor does not exceed the quotient.
// A new start may be given in the same cycle as the done_o beat.
// Reset returns the block to idle with no result pending.
`include "trial_division_prime_test_defines.svh"
module trial_division_prime_test #(
  parameter int unsigned WIDTH = tdpt_pkg::TdptWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] candidate_i,
  output logic             prime_flag_o,
  output logic             done_o
);
  import tdpt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LAUNCH = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             small_q, small_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             done_q, done_d;
  logic             flag_q, flag_d;
  logic [WIDTH-1:0] n_q, n_d;
  logic [WIDTH-1:0] d_q, d_d;

  logic             div_start;
  logic             div_done;
  logic [WIDTH-1:0] div_quo;
  logic [WIDTH-1:0] div_rem;

  tdpt_divider #(
    .WIDTH(WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .quotient_o (div_quo),
    .remainder_o(div_rem),
    .done_o     (div_done)
  );

  assign div_start = (state_q == S_LAUNCH);
  assign busy      = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    small_d = small_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    flag_d  = flag_q;
    n_d     = n_q;
    d_d     = d_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          n_d = candidate_i;
          if (candidate_i < WIDTH'(2)) begin
            done_d = 1'b1;
            flag_d = 1'b0;
          end else begin
            small_d = 1'b1;
            idx_d   = '0;
            d_d     = WIDTH'(small_prime('0));
            state_d = S_LAUNCH;
          end
        end
      end
      S_LAUNCH: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          if (small_q) begin
            if (div_rem == '0) begin
              // A small prime factor: prime only if the number is that prime.
              done_d  = 1'b1;
              flag_d  = (n_q == d_q);
              state_d = S_IDLE;
            end else if (idx_q == LastSmallIdx) begin
              small_d = 1'b0;
              d_d     = WIDTH'(FirstOddDivisor);
              state_d = S_LAUNCH;
            end else begin
              idx_d   = idx_q + 1'b1;
              d_d     = WIDTH'(small_prime(idx_q + 1'b1));
              state_d = S_LAUNCH;
            end
          end else if (d_q > div_quo) begin
            // Divisor squared exceeds the number: no factor remains.
            done_d  = 1'b1;
            flag_d  = 1'b1;
            state_d = S_IDLE;
          end else if (div_rem == '0) begin
            done_d  = 1'b1;
            flag_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            d_d     = d_q + WIDTH'(2);
            state_d = S_LAUNCH;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      small_q <= 1'b0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      small_q <= small_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q <= flag_d;
    n_q    <= n_d;
    d_q    <= d_d;
  end

  assign prime_flag_o = flag_q;
  assign done_o       = done_q;

  `TDPT_ASSERT_NOW(a_done_when_idle, done_o, !busy, "result beat while still busy")
  `TDPT_ASSERT_NEXT(a_start_progress, start && !busy, done_o || busy,
                    "accepted number neither answered nor under test")
  `TDPT_ASSERT_NOW(a_rem_below_div, div_done, div_rem < d_q,
                   "divider remainder not below the divisor")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the trial division prime tester.
module tb;

  localparam int unsigned NumW          = tdpt_pkg::TdptWidth;
  localparam int unsigned WatchdogLimit = 4_000_000;
  localparam int unsigned RandomNumbers = 78;

  typedef struct packed {
    logic [NumW-1:0] number;
    logic            known;
    logic            flag;
  } directed_row_t;

  typedef struct {
    logic [NumW-1:0] number;
    logic            flag;
  } verdict_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [NumW-1:0] candidate_i;
  logic            prime_flag_o;
  logic            done_o;

  verdict_t verdicts_pending[$];
  verdict_t oldest;
  int unsigned errors;
  int unsigned numbers_sent;
  int unsigned primes_sent;
  int unsigned verdicts_seen;
  int unsigned quiet_cycles;
  bit          gaps_on;

  // Rows with known set carry an answer that is plain from the number itself.
  directed_row_t directed_rows [22] = '{
    {32'd0,          1'b1, 1'b0},
    {32'd1,          1'b1, 1'b0},
    {32'd2,          1'b1, 1'b1},
    {32'd3,          1'b1, 1'b1},
    {32'd4,          1'b1, 1'b0},
    {32'd37,         1'b1, 1'b1},
    {32'd74,         1'b1, 1'b0},
    {32'd41,         1'b1, 1'b1},
    {32'd1369,       1'b0, 1'b0},
    {32'd1681,       1'b0, 1'b0},
    {32'd1763,       1'b0, 1'b0},
    {32'd1849,       1'b0, 1'b0},
    {32'd1847,       1'b0, 1'b0},
    {32'd65537,      1'b0, 1'b0},
    {32'd65535,      1'b0, 1'b0},
    {32'hFFFF_FFFF,  1'b1, 1'b0},
    {32'hFFFF_FFFE,  1'b1, 1'b0},
    {32'h8000_0000,  1'b1, 1'b0},
    {32'h5555_5555,  1'b0, 1'b0},
    {32'hAAAA_AAAA,  1'b1, 1'b0},
    {32'd16777213,   1'b0, 1'b0},
    {32'd1022117,    1'b0, 1'b0}
  };

  int unsigned fixed_primes [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

  trial_division_prime_test DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .candidate_i (candidate_i),
    .prime_flag_o(prime_flag_o),
    .done_o      (done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic is_prime_by_division(input logic [NumW-1:0] n);
    longint unsigned value;
    longint unsigned divisor;
    value = n;
    if (value < 2) return 1'b0;
    foreach (fixed_primes[i]) begin
      if (value % fixed_primes[i] == 0) return value == fixed_primes[i];
    end
    // The bound is written as a quotient so that it cannot overflow.
    for (divisor = 41; divisor <= value / divisor; divisor += 2) begin
      if (value % divisor == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly numbers that finish quickly; long searches are kept to moderate sizes.
  function automatic logic [NumW-1:0] pick_number();
    logic [NumW-1:0] r;
    int unsigned     p;
    int unsigned     kind;
    kind = $urandom_range(0, 99);
    r = $urandom();
    if (kind < 40) begin
      return NumW'($urandom_range(0, 65535));
    end else if (kind < 60) begin
      return NumW'($urandom_range(0, (1 << 20) - 1));
    end else if (kind < 85) begin
      p = fixed_primes[$urandom_range(0, 11)];
      return r - (r % p);
    end else if (kind < 95) begin
      return NumW'($urandom_range(20, 511) * 2 + 1) * NumW'($urandom_range(1, (1 << 20) - 1));
    end
    return NumW'($urandom_range(0, (1 << 24) - 1));
  endfunction

  // Entered and left at a falling edge; the beat is taken at the first edge with busy low.
  task automatic offer_number(input logic [NumW-1:0] n, input logic known,
                              input logic flag);
    verdict_t v;
    while (gaps_on && $urandom_range(0, 99) < 35) begin
      start       <= 1'b0;
      candidate_i <= $urandom();
      @(negedge clk_i);
    end
    start       <= 1'b1;
    candidate_i <= n;
    do @(posedge clk_i); while (busy);
    v.number = n;
    v.flag   = known ? flag : is_prime_by_division(n);
    verdicts_pending = {verdicts_pending, v};
    numbers_sent++;
    if (v.flag) primes_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_verdicts();
    while (verdicts_pending.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        verdicts_seen++;
        if (verdicts_pending.size() == 0) begin
          $display("%0t: unexpected result beat, prime flag %0b", $time, prime_flag_o);
          errors++;
        end else begin
          oldest = verdicts_pending.pop_front();
          if (prime_flag_o !== oldest.flag) begin
            $display("%0t: prime flag for %0d: expected %0b, actual %0b",
                     $time, oldest.number, oldest.flag, prime_flag_o);
            errors++;
          end
        end
      end
      if (done_o || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    start        = 1'b0;
    candidate_i  = '0;
    rst_ni       = 1'b0;
    errors       = 0;
    numbers_sent = 0;
    primes_sent  = 0;
    verdicts_seen = 0;
    quiet_cycles = 0;
    gaps_on      = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      offer_number(directed_rows[i].number, directed_rows[i].known, directed_rows[i].flag);
    end

    // Hold off until every answer so far is back before the random part.
    start <= 1'b0;
    drain_verdicts();
    repeat ($urandom_range(1, 8)) @(negedge clk_i);

    for (int i = 0; i < RandomNumbers; i++) begin
      gaps_on = (i < 30) || (i >= 60);
      offer_number(pick_number(), 1'b0, 1'b0);
    end
    start <= 1'b0;

    drain_verdicts();
    repeat (NumW + 4) @(negedge clk_i);

    $display("Tested %0d numbers (%0d fixed, %0d random), %0d of them prime; %0d checked.",
             numbers_sent, $size(directed_rows), RandomNumbers, primes_sent, verdicts_seen);
    $display("Covered values below 2, the small primes and their multiples, squares at the ",
             "search bound and full-width extremes.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_divider.sv
hw/rtl/trial_division_prime_test.sv
tb/tb.sv
